>>> rtl/iirc_pkg.sv
// ----------------------------------------------------------------------------
// iirc_pkg
// Shared types, constants and the control store of the biquad cascade.
// ----------------------------------------------------------------------------
package iirc_pkg;

  localparam int SECTIONS     = 2;
  localparam int FRAC_BITS    = 14;
  localparam int SAMPLE_WIDTH = 32;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = WORD_W + 1;
  localparam int PROD_W    = COEF_W + SAMPLE_WIDTH;
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int PC_W      = 4;

  typedef logic signed [WORD_W-1:0]       word_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]       coef_op_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic [SEC_W-1:0]               sec_t;
  typedef logic [PC_W-1:0]                pc_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

  localparam cfg_idx_t REG_B0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_B1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_B2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_A1 = cfg_idx_t'(3);
  localparam cfg_idx_t REG_A2 = cfg_idx_t'(4);
  localparam cfg_idx_t REG_LO = cfg_idx_t'(5);
  localparam cfg_idx_t REG_HI = cfg_idx_t'(6);

  localparam word_t LO_RESET = word_t'(64'shFFFF_FFFF_8000_0000);
  localparam word_t HI_RESET = word_t'(64'sh0000_0000_7FFF_FFFF);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CHECK,
    OP_MUL,
    OP_LAST,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    SEL_B0,
    SEL_B1,
    SEL_B2,
    SEL_A1,
    SEL_A2
  } sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD
  } acc_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_RANGE,
    JMP_SECTION,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
    acc_t acc;
    jmp_t jmp;
    pc_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_req;
    logic out_free;
    logic out_of_range;
  } seq_status_t;

  typedef struct packed {
    word_t b0;
    word_t b1;
    word_t b2;
    word_t a1;
    word_t a2;
    word_t lo;
    word_t hi;
  } coef_t;

  localparam pc_t PC_IDLE = pc_t'(0);
  localparam pc_t PC_LOOP = pc_t'(1);
  localparam pc_t PC_EMIT = pc_t'(8);

  // one section is steps 1..7; the last step loops back or falls to emit
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uc;
    case (pc)
      pc_t'(0): uc = '{OP_IDLE,  SEL_B0, ACC_HOLD,  JMP_WAIT_IN,  PC_IDLE};
      pc_t'(1): uc = '{OP_CHECK, SEL_B0, ACC_HOLD,  JMP_RANGE,    PC_EMIT};
      pc_t'(2): uc = '{OP_MUL,   SEL_B0, ACC_CLEAR, JMP_NEXT,     PC_IDLE};
      pc_t'(3): uc = '{OP_MUL,   SEL_B1, ACC_ADD,   JMP_NEXT,     PC_IDLE};
      pc_t'(4): uc = '{OP_MUL,   SEL_B2, ACC_ADD,   JMP_NEXT,     PC_IDLE};
      pc_t'(5): uc = '{OP_MUL,   SEL_A1, ACC_ADD,   JMP_NEXT,     PC_IDLE};
      pc_t'(6): uc = '{OP_MUL,   SEL_A2, ACC_ADD,   JMP_NEXT,     PC_IDLE};
      pc_t'(7): uc = '{OP_LAST,  SEL_B0, ACC_HOLD,  JMP_SECTION,  PC_EMIT};
      pc_t'(8): uc = '{OP_EMIT,  SEL_B0, ACC_HOLD,  JMP_WAIT_OUT, PC_IDLE};
      default:  uc = '{OP_IDLE,  SEL_B0, ACC_HOLD,  JMP_WAIT_OUT, PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

>>> rtl/iirc_seq.sv
// ----------------------------------------------------------------------------
// iirc_seq
// Step counter, section counter and jump logic over the control store.
// ----------------------------------------------------------------------------
module iirc_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  iirc_pkg::seq_status_t status,
  output iirc_pkg::ucode_t     uc,
  output iirc_pkg::sec_t       sec
);

  iirc_pkg::pc_t  pc;
  iirc_pkg::pc_t  pc_next;
  iirc_pkg::sec_t sec_next;
  logic           last_sec;

  assign uc       = iirc_pkg::ucode_rom(pc);
  assign last_sec = (sec == iirc_pkg::sec_t'(iirc_pkg::SECTIONS - 1));

  always_comb begin
    pc_next  = pc;
    sec_next = sec;
    case (uc.jmp)
      iirc_pkg::JMP_NEXT: begin
        pc_next = pc + iirc_pkg::pc_t'(1);
      end
      iirc_pkg::JMP_WAIT_IN: begin
        if (status.in_req) begin
          pc_next  = pc + iirc_pkg::pc_t'(1);
          sec_next = '0;
        end
      end
      iirc_pkg::JMP_RANGE, iirc_pkg::JMP_SECTION: begin
        if (uc.jmp == iirc_pkg::JMP_RANGE && !status.out_of_range) begin
          pc_next = pc + iirc_pkg::pc_t'(1);
        end else if (last_sec) begin
          pc_next = uc.target;
        end else begin
          pc_next  = iirc_pkg::PC_LOOP;
          sec_next = sec + iirc_pkg::sec_t'(1);
        end
      end
      iirc_pkg::JMP_WAIT_OUT: begin
        if (status.out_free) begin
          pc_next = uc.target;
        end
      end
      default: begin
        pc_next = iirc_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= iirc_pkg::PC_IDLE;
      sec <= '0;
    end else begin
      pc  <= pc_next;
      sec <= sec_next;
    end
  end

endmodule

>>> rtl/iirc_dp.sv
// ----------------------------------------------------------------------------
// iirc_dp
// Shared multiplier, accumulator, limit check and per-section delay lines.
// ----------------------------------------------------------------------------
module iirc_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  iirc_pkg::ucode_t      uc,
  input  iirc_pkg::sec_t        sec,
  input  iirc_pkg::coef_t       cfg,
  input  logic                  in_req,
  input  iirc_pkg::word_t       sample_in,
  output logic                  out_of_range,
  output iirc_pkg::sample_t     v,
  output logic                  err
);

  iirc_pkg::sample_t  x1 [iirc_pkg::SECTIONS];
  iirc_pkg::sample_t  x2 [iirc_pkg::SECTIONS];
  iirc_pkg::sample_t  y1 [iirc_pkg::SECTIONS];
  iirc_pkg::sample_t  y2 [iirc_pkg::SECTIONS];

  iirc_pkg::prod_t    prod;
  iirc_pkg::sample_t  acc;
  iirc_pkg::sample_t  term;
  iirc_pkg::sample_t  sum;
  iirc_pkg::word_t    v_ext;
  iirc_pkg::coef_op_t coef_op;
  iirc_pkg::sample_t  mul_op;

  assign v_ext        = iirc_pkg::word_t'(v);
  assign out_of_range = (v_ext < $signed(cfg.lo)) || (v_ext > $signed(cfg.hi));

  // floor shift of the registered product, wrapped to sample width
  assign term = $signed(prod[iirc_pkg::FRAC_BITS +: iirc_pkg::SAMPLE_WIDTH]);
  assign sum  = acc + term;

  always_comb begin
    case (uc.sel)
      iirc_pkg::SEL_B0: begin
        coef_op = iirc_pkg::coef_op_t'($signed(cfg.b0));
        mul_op  = v;
      end
      iirc_pkg::SEL_B1: begin
        coef_op = iirc_pkg::coef_op_t'($signed(cfg.b1));
        mul_op  = x1[sec];
      end
      iirc_pkg::SEL_B2: begin
        coef_op = iirc_pkg::coef_op_t'($signed(cfg.b2));
        mul_op  = x2[sec];
      end
      iirc_pkg::SEL_A1: begin
        // negated before the product, so the floor matches -a * y
        coef_op = -iirc_pkg::coef_op_t'($signed(cfg.a1));
        mul_op  = y1[sec];
      end
      iirc_pkg::SEL_A2: begin
        coef_op = -iirc_pkg::coef_op_t'($signed(cfg.a2));
        mul_op  = y2[sec];
      end
      default: begin
        coef_op = '0;
        mul_op  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= coef_op * mul_op;
    case (uc.acc)
      iirc_pkg::ACC_CLEAR: acc <= '0;
      iirc_pkg::ACC_ADD:   acc <= sum;
      default:             acc <= acc;
    endcase
    case (uc.op)
      iirc_pkg::OP_IDLE: begin
        if (in_req) begin
          v   <= iirc_pkg::sample_t'(sample_in[iirc_pkg::SAMPLE_WIDTH-1:0]);
          err <= 1'b0;
        end
      end
      iirc_pkg::OP_CHECK: begin
        if (out_of_range) begin
          v   <= '0;
          err <= 1'b1;
        end
      end
      iirc_pkg::OP_LAST: begin
        v <= sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iirc_pkg::SECTIONS; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else if (uc.op == iirc_pkg::OP_LAST) begin
      x2[sec] <= x1[sec];
      x1[sec] <= v;
      y2[sec] <= y1[sec];
      y1[sec] <= sum;
    end
  end

endmodule

>>> rtl/fixed_point_iir_cascade.sv
// ----------------------------------------------------------------------------
// fixed_point_iir_cascade
// Cascade of direct-form-I biquad sections on one shared multiplier.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with sample_in. A request is taken when
// in_valid is high and in_stall is low; in_stall stays high while a sample is
// being filtered.
// Output channel: out_valid / out_stall with sample_out and range_error. The
// result sits in an output register and holds while out_stall is high.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
// ready, to be written only while no sample is in flight.
// Sequence: each section runs the limit check, five products through the one
// multiplier, then the final add and delay update; a section whose input is
// out of limits runs the limit check only. A result is registered in the
// emit step after the last section, and the next request is taken once the
// sequencer is back in idle. The multiplier takes one product per cycle.
// A stalled result holds the sequencer in the emit step; no new sample is
// taken meanwhile, and the input waits until the output register frees up.
// Reset clears all delay lines, loads the reset coefficients and limits and
// empties the output register.
// ----------------------------------------------------------------------------
module fixed_point_iir_cascade (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  iirc_pkg::word_t          sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output iirc_pkg::word_t          sample_out,
  output logic                     range_error,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  iirc_pkg::cfg_idx_t       cfg_index,
  input  iirc_pkg::word_t          cfg_data
);

  iirc_pkg::coef_t       cfg;
  iirc_pkg::ucode_t      uc;
  iirc_pkg::sec_t        sec;
  iirc_pkg::seq_status_t status;
  iirc_pkg::sample_t     v;
  logic                  err;
  logic                  out_of_range;
  logic                  in_req;
  logic                  out_free;
  logic                  out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (uc.op != iirc_pkg::OP_IDLE);
  assign in_req    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (uc.op == iirc_pkg::OP_EMIT) && out_free;

  assign status.in_req       = in_req;
  assign status.out_free     = out_free;
  assign status.out_of_range = out_of_range;

  iirc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uc     (uc),
    .sec    (sec)
  );

  iirc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .uc           (uc),
    .sec          (sec),
    .cfg          (cfg),
    .in_req       (in_req),
    .sample_in    (sample_in),
    .out_of_range (out_of_range),
    .v            (v),
    .err          (err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0 <= '0;
      cfg.b1 <= '0;
      cfg.b2 <= '0;
      cfg.a1 <= '0;
      cfg.a2 <= '0;
      cfg.lo <= iirc_pkg::LO_RESET;
      cfg.hi <= iirc_pkg::HI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iirc_pkg::REG_B0: cfg.b0 <= cfg_data;
        iirc_pkg::REG_B1: cfg.b1 <= cfg_data;
        iirc_pkg::REG_B2: cfg.b2 <= cfg_data;
        iirc_pkg::REG_A1: cfg.a1 <= cfg_data;
        iirc_pkg::REG_A2: cfg.a2 <= cfg_data;
        iirc_pkg::REG_LO: cfg.lo <= cfg_data;
        iirc_pkg::REG_HI: cfg.hi <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out  <= iirc_pkg::word_t'(v);
      range_error <= err;
    end
  end

endmodule

>>> rtl/iirc_checker.sv
// ----------------------------------------------------------------------------
// iirc_checker
// Port-level checks on request flow and result timing of the cascade.
// ----------------------------------------------------------------------------
module iirc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input iirc_pkg::word_t    sample_out,
  input logic               range_error
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(range_error))
    else $error("result changed while stalled");

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a taken request keeps the input closed through the check step and the step after it
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input reopened too early");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

endmodule

bind fixed_point_iir_cascade iirc_checker u_iirc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sample_out  (sample_out),
  .range_error (range_error)
);

>>> sim/iir_cascade_checker.sv
// ----------------------------------------------------------------------------
// iir_cascade_checker
// Watches the sample, result and control channels of the biquad cascade. It
// keeps its own copy of the coefficients, limits and per-section delay lines,
// filters every accepted sample, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module iir_cascade_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  iirc_pkg::word_t     sample_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  iirc_pkg::word_t     sample_out,
  input  logic                range_error,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  iirc_pkg::cfg_idx_t  cfg_index,
  input  iirc_pkg::word_t     cfg_data,
  output int                  mismatch_count,
  output int                  outstanding
);

  typedef struct {
    iirc_pkg::word_t value;
    logic            out_of_range;
  } filtered_t;

  filtered_t       predicted_q[$];
  iirc_pkg::word_t ctrl_reg [7];
  iirc_pkg::word_t in_d1 [iirc_pkg::SECTIONS];
  iirc_pkg::word_t in_d2 [iirc_pkg::SECTIONS];
  iirc_pkg::word_t out_d1 [iirc_pkg::SECTIONS];
  iirc_pkg::word_t out_d2 [iirc_pkg::SECTIONS];
  int              result_no;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
    result_no = 0;
  end

  function automatic logic signed [iirc_pkg::WORD_W:0] widen(input iirc_pkg::word_t w);
    return $signed({w[iirc_pkg::WORD_W-1], w});
  endfunction

  // exact product, floor shift, then wrap to the sample width
  function automatic iirc_pkg::word_t scaled_product(
      input logic signed [iirc_pkg::WORD_W:0] coef, input iirc_pkg::word_t v);
    logic signed [2*iirc_pkg::WORD_W+1:0] full;
    full = coef * v;
    return iirc_pkg::word_t'(full >>> iirc_pkg::FRAC_BITS);
  endfunction

  task automatic filter_sample(input iirc_pkg::word_t x, output filtered_t res);
    iirc_pkg::word_t v;
    iirc_pkg::word_t acc;
    int              s;
    v = x;
    res.out_of_range = 1'b0;
    for (s = 0; s < iirc_pkg::SECTIONS; s++) begin
      if (v < ctrl_reg[iirc_pkg::REG_LO] || v > ctrl_reg[iirc_pkg::REG_HI]) begin
        // rejected section passes a zero on and keeps its delays
        res.out_of_range = 1'b1;
        v = '0;
      end else begin
        acc = scaled_product(widen(ctrl_reg[iirc_pkg::REG_B0]), v);
        acc += scaled_product(widen(ctrl_reg[iirc_pkg::REG_B1]), in_d1[s]);
        acc += scaled_product(widen(ctrl_reg[iirc_pkg::REG_B2]), in_d2[s]);
        acc += scaled_product(-widen(ctrl_reg[iirc_pkg::REG_A1]), out_d1[s]);
        acc += scaled_product(-widen(ctrl_reg[iirc_pkg::REG_A2]), out_d2[s]);
        in_d2[s] = in_d1[s];
        in_d1[s] = v;
        out_d2[s] = out_d1[s];
        out_d1[s] = acc;
        v = acc;
      end
    end
    res.value = v;
  endtask

  task automatic report_mismatch(input string field, input iirc_pkg::word_t got,
                                 input iirc_pkg::word_t want);
    $display("mismatch at result %0d, %s: got %0d, expected %0d",
             result_no, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    filtered_t want;
    filtered_t got;
    if (rst) begin
      ctrl_reg[iirc_pkg::REG_B0] = '0;
      ctrl_reg[iirc_pkg::REG_B1] = '0;
      ctrl_reg[iirc_pkg::REG_B2] = '0;
      ctrl_reg[iirc_pkg::REG_A1] = '0;
      ctrl_reg[iirc_pkg::REG_A2] = '0;
      ctrl_reg[iirc_pkg::REG_LO] = iirc_pkg::LO_RESET;
      ctrl_reg[iirc_pkg::REG_HI] = iirc_pkg::HI_RESET;
      for (int s = 0; s < iirc_pkg::SECTIONS; s++) begin
        in_d1[s] = '0;
        in_d2[s] = '0;
        out_d1[s] = '0;
        out_d2[s] = '0;
      end
      predicted_q.delete();
    end else begin
      // results are checked before the request of the same edge is queued
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result with no request waiting", sample_out, '0);
        end else begin
          want = predicted_q.pop_front();
          if (sample_out !== want.value) begin
            report_mismatch("sample_out", sample_out, want.value);
          end
          if (range_error !== want.out_of_range) begin
            report_mismatch("range_error", iirc_pkg::word_t'(range_error),
                            iirc_pkg::word_t'(want.out_of_range));
          end
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready && cfg_index <= iirc_pkg::REG_HI) begin
        ctrl_reg[cfg_index] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        filter_sample(sample_in, got);
        predicted_q.push_back(got);
      end
    end
    outstanding = predicted_q.size();
  end

endmodule

>>> sim/fixed_point_iir_cascade_test.sv
// ----------------------------------------------------------------------------
// fixed_point_iir_cascade_test
// Drives samples and control writes into the biquad cascade: directed edge
// values and limit cases first, then random coefficient sets and samples under
// varying sender and receiver idling, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module fixed_point_iir_cascade_test;

  localparam int                 CYCLE_LIMIT   = 400000;
  localparam int                 RANDOM_BLOCKS = 6;
  localparam int                 BLOCK_ITEMS   = 190;
  localparam iirc_pkg::cfg_idx_t REG_UNUSED    = iirc_pkg::cfg_idx_t'(7);
  localparam iirc_pkg::word_t    WORD_MIN      = iirc_pkg::word_t'(32'h8000_0000);
  localparam iirc_pkg::word_t    WORD_MAX      = iirc_pkg::word_t'(32'h7FFF_FFFF);

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  iirc_pkg::word_t    sample_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  iirc_pkg::word_t    sample_out;
  logic               range_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  iirc_pkg::cfg_idx_t cfg_index = '0;
  iirc_pkg::word_t    cfg_data = '0;

  int              mismatch_count;
  int              outstanding;
  int              send_idle_pct = 34;
  int              recv_idle_pct = 57;
  int              stall_burst = 0;
  int              cycle_count = 0;
  iirc_pkg::word_t lo_now = WORD_MIN;
  iirc_pkg::word_t hi_now = WORD_MAX;

  fixed_point_iir_cascade u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .range_error (range_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  iir_cascade_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_out     (sample_out),
    .range_error    (range_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial forever #6 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fixed_point_iir_cascade regression: fail");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial forever begin
    @(posedge clk);
    if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input iirc_pkg::cfg_idx_t idx, input iirc_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_filter(input iirc_pkg::word_t b0, input iirc_pkg::word_t b1,
                            input iirc_pkg::word_t b2, input iirc_pkg::word_t a1,
                            input iirc_pkg::word_t a2, input iirc_pkg::word_t lo,
                            input iirc_pkg::word_t hi);
    write_reg(iirc_pkg::REG_B0, b0);
    write_reg(iirc_pkg::REG_B1, b1);
    write_reg(iirc_pkg::REG_B2, b2);
    write_reg(iirc_pkg::REG_A1, a1);
    write_reg(iirc_pkg::REG_A2, a2);
    write_reg(iirc_pkg::REG_LO, lo);
    write_reg(iirc_pkg::REG_HI, hi);
    // out-of-map index must not disturb anything
    write_reg(REG_UNUSED, iirc_pkg::word_t'($urandom));
    cfg_valid <= 1'b0;
    lo_now = lo;
    hi_now = hi;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_sample(input iirc_pkg::word_t x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic iirc_pkg::word_t random_coef();
    if ($urandom_range(0, 3) == 0) begin
      return iirc_pkg::word_t'($urandom);
    end
    return iirc_pkg::word_t'(int'($urandom_range(0, 65535)) - 32768);
  endfunction

  task automatic random_filter();
    iirc_pkg::word_t lo;
    iirc_pkg::word_t hi;
    iirc_pkg::word_t span;
    case ($urandom_range(0, 3))
      0, 1: begin
        lo = WORD_MIN;
        hi = WORD_MAX;
      end
      2: begin
        span = iirc_pkg::word_t'(1 << $urandom_range(8, 30));
        lo = -span;
        hi = span - 1;
      end
      default: begin
        // may cross
        lo = iirc_pkg::word_t'($urandom);
        hi = iirc_pkg::word_t'($urandom);
      end
    endcase
    set_filter(random_coef(), random_coef(), random_coef(), random_coef(),
               random_coef(), lo, hi);
  endtask

  function automatic iirc_pkg::word_t random_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1: begin
        if ($urandom_range(0, 1)) return lo_now + int'($urandom_range(0, 2)) - 1;
        return hi_now + int'($urandom_range(0, 2)) - 1;
      end
      2, 3, 4, 5: return iirc_pkg::word_t'(int'($urandom_range(0, 131071)) - 65536);
      default: return iirc_pkg::word_t'($urandom);
    endcase
  endfunction

  initial begin
    iirc_pkg::word_t plain_probe [12];
    iirc_pkg::word_t limit_probe [7];
    iirc_pkg::word_t cross_probe [3];
    iirc_pkg::word_t wrap_probe [3];
    plain_probe = '{0, 1, -1, WORD_MAX, WORD_MIN, 32'h5555_5555, 32'hAAAA_AAAA,
                    16384, -16384, 1000, -1000, 0};
    limit_probe = '{-50000, 50000, -50001, 50001, 40000, WORD_MAX, WORD_MIN};
    cross_probe = '{0, 5, -5};
    wrap_probe = '{WORD_MIN, WORD_MAX, -1};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ordinary filter, then narrow, crossed and full-scale settings
    set_filter(16384, -8192, 4096, -12000, 5000, WORD_MIN, WORD_MAX);
    foreach (plain_probe[i]) send_sample(plain_probe[i]);
    drain();
    set_filter(16384, -8192, 4096, -12000, 5000, -50000, 50000);
    foreach (limit_probe[i]) send_sample(limit_probe[i]);
    drain();
    set_filter(16384, 0, 0, 0, 0, 100, -100);
    foreach (cross_probe[i]) send_sample(cross_probe[i]);
    drain();
    set_filter(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
    foreach (wrap_probe[i]) send_sample(wrap_probe[i]);
    drain();

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 2) begin
        send_idle_pct = 57;
        recv_idle_pct = 34;
      end
      if (blk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_filter();
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // long receiver hold-off while samples keep coming
        if (blk == 1 && n == 50) stall_burst = 400;
        send_sample(random_sample());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("fixed_point_iir_cascade regression: pass");
    end else begin
      $display("fixed_point_iir_cascade regression: fail");
    end
    $finish;
  end

endmodule
